>>> rtl/core/glyph_pixel_store_top_assert.svh
// assertion macros for the glyph pixel store, included by gps_back
`ifndef GLYPH_PIXEL_STORE_TOP_ASSERT_SVH
`define GLYPH_PIXEL_STORE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GPS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GPS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GPS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define GPS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/core/gps_pkg.sv
`default_nettype none

package gps_pkg;

    // default sizes
    localparam int STORE_BYTES_DEF = 16384;
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_HEIGHT_DEF  = 64;

    // pixel format limits
    localparam int BPP_MAX  = 32;
    localparam int RGB_BPP  = 3 * 8;
    localparam int RGBA_BPP = 4 * 8;

    // byte offset width, bounded by the 7-bit size registers
    localparam int OFFSET_W = 18;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        LAYOUT_PLANES = 2'd0,
        LAYOUT_BYTES  = 2'd1,
        LAYOUT_RGB    = 2'd2,
        LAYOUT_RGBA   = 2'd3
    } layout_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_BPP    = 2'd2,
        CFG_LAYOUT = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } command_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_SETTINGS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_PLANE = 2'd1,
        KIND_BYTES = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FR_IDLE = 2'd0,
        FR_MUL1 = 2'd1,
        FR_MUL2 = 2'd2,
        FR_PUSH = 2'd3
    } front_state_t;

    typedef enum logic [2:0] {
        BK_CLEAR = 3'd0,
        BK_IDLE  = 3'd1,
        BK_READ  = 3'd2,
        BK_DATA  = 3'd3,
        BK_WRITE = 3'd4,
        BK_DONE  = 3'd5
    } back_state_t;

    typedef struct packed {
        command_t    command;
        logic [5:0]  column;
        logic [5:0]  row;
        logic [31:0] pixel_value;
    } item_t;

    typedef struct packed {
        logic [31:0] read_value;
        status_t     status;
    } result_t;

    typedef struct packed {
        logic [6:0] glyph_width;
        logic [6:0] glyph_height;
        logic [5:0] bits_per_pixel;
        layout_t    layout;
    } cfg_t;

    // one classified access handed from front to back
    typedef struct packed {
        kind_t                kind;
        logic                 write;
        logic                 big_endian;
        logic [5:0]           count;
        logic [4:0]           stride;
        logic [2:0]           bit_pos;
        logic [OFFSET_W-1:0]  offset;
        logic [31:0]          value;
        status_t              status;
    } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/gps_front.sv
`default_nettype none

module gps_front
    import gps_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   hold,
    input  wire logic   push,
    output logic        full,
    input  wire item_t  item,
    output logic        q_push,
    input  wire logic   q_full,
    output entry_t      q_entry
);

    front_state_t state_reg, state_next;

    logic                cmd_reg;
    logic [5:0]          x_reg;
    logic [5:0]          y_reg;
    logic [31:0]         value_reg;

    logic [4:0]          pb_reg;
    logic [3:0]          n_reg;
    logic [10:0]         xpb_reg;
    logic [12:0]         xh_reg;
    logic [11:0]         pw_reg;
    logic [10:0]         nw_reg;
    logic                cfg_ok_reg;
    logic                range_ok_reg;

    logic [OFFSET_W-1:0] base_plane_reg;
    logic [OFFSET_W-1:0] base_byte_reg;
    logic [OFFSET_W-1:0] size_reg;

    logic [4:0]          pb;
    logic [3:0]          n;
    logic                cfg_ok;
    logic                range_ok;
    logic                size_ok;
    logic                accept;
    status_t             status;

    // plane stride and bytes per pixel
    always_comb
    begin
        pb = 5'((9'(cfg.glyph_height) + 9'd7) >> 3);
        case (cfg.layout)
            LAYOUT_RGB:  n = 4'd3;
            LAYOUT_RGBA: n = 4'd4;
            default:     n = 4'((7'(cfg.bits_per_pixel) + 7'd7) >> 3);
        endcase
    end

    // settings and position checks
    always_comb
    begin
        cfg_ok = (cfg.glyph_width != 7'd0)
              && (32'(cfg.glyph_width) <= MAX_WIDTH)
              && (cfg.glyph_height != 7'd0)
              && (32'(cfg.glyph_height) <= MAX_HEIGHT)
              && (cfg.bits_per_pixel != 6'd0)
              && (32'(cfg.bits_per_pixel) <= BPP_MAX)
              && !(cfg.layout == LAYOUT_RGB && 32'(cfg.bits_per_pixel) != RGB_BPP)
              && !(cfg.layout == LAYOUT_RGBA && 32'(cfg.bits_per_pixel) != RGBA_BPP);
        range_ok = (7'(x_reg) < cfg.glyph_width) && (7'(y_reg) < cfg.glyph_height);
        size_ok  = 32'(size_reg) <= STORE_BYTES;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FR_IDLE: if (accept) state_next = FR_MUL1;
            FR_MUL1: state_next = FR_MUL2;
            FR_MUL2: state_next = FR_PUSH;
            FR_PUSH: if (!q_full) state_next = FR_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        full    = 1'b1;
        q_push  = 1'b0;
        unique case (state_reg)
            FR_IDLE: full = hold;
            FR_MUL1: full = 1'b1;
            FR_MUL2: full = 1'b1;
            FR_PUSH: q_push = !q_full;
        endcase
    end

    assign accept = push && !full;

    // classify the access
    always_comb
    begin
        if (!cfg_ok_reg || !size_ok)
            status = STATUS_SETTINGS;
        else if (!range_ok_reg)
            status = STATUS_RANGE;
        else
            status = STATUS_OK;

        q_entry.status     = status;
        q_entry.write      = (cmd_reg == CMD_WRITE);
        q_entry.value      = value_reg;
        q_entry.bit_pos    = 3'd7 - y_reg[2:0];
        q_entry.big_endian = (cfg.layout != LAYOUT_BYTES);
        if (cfg.layout == LAYOUT_PLANES)
        begin
            q_entry.kind   = KIND_PLANE;
            q_entry.offset = base_plane_reg;
            q_entry.count  = cfg.bits_per_pixel;
            q_entry.stride = pb_reg;
        end
        else
        begin
            q_entry.kind   = KIND_BYTES;
            q_entry.offset = base_byte_reg;
            q_entry.count  = 6'(n_reg);
            q_entry.stride = 5'd1;
        end
        if (status != STATUS_OK)
            q_entry.kind = KIND_NONE;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FR_IDLE;
        else
            state_reg <= state_next;
    end

    // item capture and address arithmetic
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= item.command;
            x_reg     <= item.column;
            y_reg     <= item.row;
            value_reg <= item.pixel_value;
        end
        if (state_reg == FR_MUL1)
        begin
            pb_reg       <= pb;
            n_reg        <= n;
            xpb_reg      <= 11'(x_reg) * 11'(pb);
            xh_reg       <= 13'(x_reg) * 13'(cfg.glyph_height);
            pw_reg       <= 12'(pb) * 12'(cfg.glyph_width);
            nw_reg       <= 11'(n) * 11'(cfg.glyph_width);
            cfg_ok_reg   <= cfg_ok;
            range_ok_reg <= range_ok;
        end
        if (state_reg == FR_MUL2)
        begin
            base_plane_reg <= OFFSET_W'(xpb_reg) * OFFSET_W'(pb_reg == 5'd0 ? 6'd0 : cfg.bits_per_pixel)
                            + OFFSET_W'(y_reg[5:3]);
            base_byte_reg  <= (OFFSET_W'(y_reg) + OFFSET_W'(xh_reg)) * OFFSET_W'(n_reg);
            if (cfg.layout == LAYOUT_PLANES)
                size_reg <= OFFSET_W'(pw_reg) * OFFSET_W'(cfg.bits_per_pixel);
            else
                size_reg <= OFFSET_W'(nw_reg) * OFFSET_W'(cfg.glyph_height);
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gps_queue.sv
`default_nettype none

module gps_queue
    import gps_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_push,
    input  wire entry_t q_in,
    output logic        q_full,
    input  wire logic   q_pop,
    output entry_t      q_head,
    output logic        q_empty
);

    entry_t                 slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign q_full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;
    assign q_head  = slots_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= q_in;
    end

endmodule

`default_nettype wire

>>> rtl/core/gps_back.sv
`default_nettype none

`include "glyph_pixel_store_top_assert.svh"

module gps_back
    import gps_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    output logic        clearing,
    input  wire entry_t q_head,
    input  wire logic   q_empty,
    output logic        q_pop,
    output result_t     result,
    output logic        empty,
    input  wire logic   pop
);

    localparam int AW = $clog2(STORE_BYTES);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);

    logic [7:0] glyph_bytes [STORE_BYTES];

    back_state_t state_reg, state_next;

    logic [AW-1:0] clear_addr_reg;
    logic          out_valid_reg;
    result_t       out_reg;

    kind_t         kind_reg;
    logic          write_reg;
    logic          big_endian_reg;
    logic [5:0]    count_reg;
    logic [4:0]    stride_reg;
    logic [2:0]    bit_pos_reg;
    logic [AW-1:0] addr_reg;
    logic [31:0]   value_reg;
    status_t       status_reg;
    logic [4:0]    bit_idx_reg;
    logic [1:0]    byte_sel_reg;
    logic [31:0]   acc_reg;
    logic [7:0]    rd_data_reg;

    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic          out_load;
    logic          last_step;
    logic [31:0]   head_offset32;
    logic [5:0]    head_count_m1;
    logic [7:0]    bit_mask;
    logic [7:0]    plane_byte;
    logic [7:0]    value_byte;

    assign head_offset32 = 32'(q_head.offset);
    assign head_count_m1 = q_head.count - 6'd1;
    assign last_step     = (count_reg == 6'd1);
    assign bit_mask      = 8'd1 << bit_pos_reg;
    assign plane_byte    = value_reg[bit_idx_reg] ? (rd_data_reg | bit_mask)
                                                  : (rd_data_reg & ~bit_mask);
    assign value_byte    = value_reg[{byte_sel_reg, 3'b000} +: 8];
    assign clearing      = (state_reg == BK_CLEAR);
    assign empty         = !out_valid_reg;
    assign result        = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_CLEAR: if (clear_addr_reg == LAST_ADDR) state_next = BK_IDLE;
            BK_IDLE:
                if (!q_empty)
                begin
                    if (q_head.kind == KIND_NONE)
                        state_next = BK_DONE;
                    else if (q_head.kind == KIND_BYTES && q_head.write)
                        state_next = BK_WRITE;
                    else
                        state_next = BK_READ;
                end
            BK_READ:  state_next = BK_DATA;
            BK_DATA:  state_next = last_step ? BK_DONE : BK_READ;
            BK_WRITE: if (last_step) state_next = BK_DONE;
            BK_DONE:  if (!out_valid_reg || pop) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = addr_reg;
        mem_wdata = value_byte;
        out_load  = 1'b0;
        unique case (state_reg)
            BK_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clear_addr_reg;
                mem_wdata = 8'd0;
            end
            BK_IDLE:  q_pop = !q_empty;
            BK_READ:  mem_we = 1'b0;
            BK_DATA:
            begin
                mem_we    = write_reg;
                mem_wdata = plane_byte;
            end
            BK_WRITE: mem_we = 1'b1;
            BK_DONE:  out_load = !out_valid_reg || pop;
            default:  mem_we = 1'b0;
        endcase
    end

    // glyph byte memory, one port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            glyph_bytes[mem_addr] <= mem_wdata;
        rd_data_reg <= glyph_bytes[mem_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
                clear_addr_reg <= clear_addr_reg + 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
        end
    end

    // access sequencing
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kind_reg       <= q_head.kind;
            write_reg      <= q_head.write;
            big_endian_reg <= q_head.big_endian;
            count_reg      <= q_head.count;
            stride_reg     <= q_head.stride;
            bit_pos_reg    <= q_head.bit_pos;
            addr_reg       <= head_offset32[AW-1:0];
            value_reg      <= q_head.value;
            status_reg     <= q_head.status;
            bit_idx_reg    <= 5'd0;
            byte_sel_reg   <= q_head.big_endian ? head_count_m1[1:0] : 2'd0;
            acc_reg        <= '0;
        end
        if (state_reg == BK_DATA || state_reg == BK_WRITE)
        begin
            if (state_reg == BK_DATA && !write_reg)
            begin
                if (kind_reg == KIND_PLANE)
                    acc_reg[bit_idx_reg] <= rd_data_reg[bit_pos_reg];
                else
                    acc_reg[{byte_sel_reg, 3'b000} +: 8] <= rd_data_reg;
            end
            addr_reg     <= addr_reg + AW'(stride_reg);
            count_reg    <= count_reg - 6'd1;
            bit_idx_reg  <= bit_idx_reg + 5'd1;
            byte_sel_reg <= big_endian_reg ? byte_sel_reg - 2'd1 : byte_sel_reg + 2'd1;
        end
        if (out_load)
        begin
            out_reg.read_value <= acc_reg;
            out_reg.status     <= status_reg;
        end
    end

    // no queue transfer before the clearing pass is over
    `GPS_ASSERT_IMP(a_no_pop_in_clear, clk, rst_n, state_reg == BK_CLEAR, !q_pop,
        "queue popped during clearing pass")

    // a byte step never runs with an exhausted count
    `GPS_ASSERT_IMP(a_count_live, clk, rst_n,
        state_reg == BK_DATA || state_reg == BK_WRITE, count_reg != 6'd0,
        "byte step with zero count")

    // memory written only by the clear pass or a pixel write
    `GPS_ASSERT_IMP(a_write_source, clk, rst_n, mem_we,
        state_reg == BK_CLEAR || (write_reg && (state_reg == BK_DATA || state_reg == BK_WRITE)),
        "unexpected memory write")

    // error results carry a zero value
    `GPS_ASSERT_NXT(a_error_zero, clk, rst_n, out_load && status_reg != STATUS_OK,
        out_reg.read_value == 32'd0, "error result with nonzero value")

endmodule

`default_nettype wire

>>> rtl/core/glyph_pixel_store_top.sv
// glyph pixel store: reads and writes one pixel of a glyph byte store per item
// an item runs through front states MUL1, MUL2 and PUSH, the queue and the back,
// which takes a READ and a DATA step per plane or byte read (one WRITE step per byte
// for full-byte, RGB and RGBA writes); a waiting result stalls; the front takes a
// new item once it has pushed the last. reset: config returns to 8x8, 1 bpp, bit
// planes; the byte store is then cleared one byte a cycle while full stays high
`default_nettype none

module glyph_pixel_store_top
    import gps_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire cfg_index_t cfg_index,
    input  wire logic [6:0] cfg_data,
    input  wire logic       push,
    output logic            full,
    input  wire item_t      item,
    output logic            empty,
    input  wire logic       pop,
    output result_t         result
);

    cfg_t   cfg_reg;
    logic   clearing;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;
    entry_t q_in;
    entry_t q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width    <= 7'd8;
            cfg_reg.glyph_height   <= 7'd8;
            cfg_reg.bits_per_pixel <= 6'd1;
            cfg_reg.layout         <= LAYOUT_PLANES;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  cfg_reg.glyph_width    <= cfg_data;
                CFG_HEIGHT: cfg_reg.glyph_height   <= cfg_data;
                CFG_BPP:    cfg_reg.bits_per_pixel <= cfg_data[5:0];
                CFG_LAYOUT: cfg_reg.layout         <= layout_t'(cfg_data[1:0]);
            endcase
        end
    end

    // front: capture and classify
    gps_front #(
        .STORE_BYTES (STORE_BYTES),
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .hold    (clearing),
        .push    (push),
        .full    (full),
        .item    (item),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_entry (q_in)
    );

    // decoupling queue
    gps_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_in    (q_in),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_empty (q_empty)
    );

    // back: memory access and result register
    gps_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .result   (result),
        .empty    (empty),
        .pop      (pop)
    );

endmodule

`default_nettype wire
